// ===== rtl/tdl_pkg.sv =====
// Shared types, constants and helper functions for the dwell table.
package tdl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int ID_W      = 32;
    localparam int PRESENT_W = 16;
    localparam int MISSING_W = 8;
    localparam int CHAN_W    = 8;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // Operation codes of an input transfer
    localparam logic OP_TRACK = 1'b0;
    localparam logic OP_EOF   = 1'b1;

    // Register word indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MAX_LOST  = 1'b1;

    localparam logic [PRESENT_W-1:0] THRESHOLD_RST = 16'd100;
    localparam logic [MISSING_W-1:0] MAX_LOST_RST  = 8'd30;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [PRESENT_W-1:0] present;
        logic [MISSING_W-1:0] missing;
    } entry_t;

    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [PRESENT_W-1:0] threshold;
        logic [MISSING_W-1:0] max_lost;
    } cfg_t;

    function automatic logic [PRESENT_W-1:0] present_inc(input logic [PRESENT_W-1:0] v);
        logic [PRESENT_W-1:0] r;
        r = (v == '1) ? v : v + PRESENT_W'(1);
        return r;
    endfunction

    function automatic logic [MISSING_W-1:0] missing_inc(input logic [MISSING_W-1:0] v);
        logic [MISSING_W-1:0] r;
        r = (v == '1) ? v : v + MISSING_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/track_dwell_loiter_table_top.sv =====
// Track dwell/loiter table: a track transfer sweeps the entry RAM read port
// (registered read data) and writes back once; an end-of-frame transfer
// sweeps the table to age it before its result goes out. One transfer is
// worked on at a time; a finished result waits in the output register while
// the next transfer is taken. Reset clears all entries, seen marks and frame
// flags at once and loads the register defaults.
module track_dwell_loiter_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [tdl_pkg::ID_W-1:0]      obj_id,
    input  logic [tdl_pkg::CHAN_W-1:0]    channel_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          loiter_alarm,
    output logic                          table_overflow,
    output logic [tdl_pkg::CHAN_W-1:0]    out_channel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdl_pkg::ADDR_W-1:0]    paddr,
    input  logic [tdl_pkg::DATA_W-1:0]    pwdata,
    output logic [tdl_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import tdl_pkg::*;

    cfg_t     cfg;
    ram_req_t ram_req;
    entry_t   rd_data;

    // Register block
    tdl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    tdl_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .obj_id         (obj_id),
        .channel_id     (channel_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .loiter_alarm   (loiter_alarm),
        .table_overflow (table_overflow),
        .out_channel    (out_channel),
        .cfg            (cfg),
        .ram_req        (ram_req),
        .rd_data        (rd_data)
    );

    // Entry store
    tdl_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    // No read and write of the same entry in one cycle
    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.rd_en && ram_req.wr_en && (ram_req.rd_addr == ram_req.wr_addr)))
        else $error("entry read and written in the same cycle");

    // The entry store is never written while idle
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !ram_req.wr_en)
        else $error("entry write while idle");

    // A pending result is only dropped by an output transfer
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without a transfer");

    // An end-of-frame transfer starts a read sweep in the next cycle
    a_eof_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == OP_EOF)) |=> ram_req.rd_en)
        else $error("end of frame without a sweep");
`endif

endmodule

// ===== rtl/tdl_ram.sv =====
// Entry store: one write port, one read port, registered read data.
module tdl_ram (
    input  logic              clk,
    input  tdl_pkg::ram_req_t req,
    output tdl_pkg::entry_t   rd_data
);
    import tdl_pkg::*;

    entry_t entry_mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= entry_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tdl_cfg.sv =====
// APB register block: loiter threshold and missing-frame limit.
module tdl_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tdl_pkg::ADDR_W-1:0]  paddr,
    input  logic [tdl_pkg::DATA_W-1:0]  pwdata,
    output logic [tdl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output tdl_pkg::cfg_t               cfg
);
    import tdl_pkg::*;

    logic [PRESENT_W-1:0] threshold_reg;
    logic [MISSING_W-1:0] max_lost_reg;
    logic                 wr_stb;
    logic                 word_idx;

    assign pready   = 1'b1;
    assign wr_stb   = psel & penable & pwrite;
    assign word_idx = paddr[2];

    // Take register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            max_lost_reg  <= MAX_LOST_RST;
        end
        else if (wr_stb)
        begin
            unique case (word_idx)
                REG_THRESHOLD: threshold_reg <= pwdata[PRESENT_W-1:0];
                REG_MAX_LOST:  max_lost_reg  <= pwdata[MISSING_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (word_idx)
            REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            REG_MAX_LOST:  prdata = DATA_W'(max_lost_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.max_lost  = max_lost_reg;

endmodule

// ===== rtl/tdl_ctrl.sv =====
// Sweep sequencer: lookup/insert on track transfers, ageing on end of frame.
module tdl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [tdl_pkg::ID_W-1:0]      obj_id,
    input  logic [tdl_pkg::CHAN_W-1:0]    channel_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          loiter_alarm,
    output logic                          table_overflow,
    output logic [tdl_pkg::CHAN_W-1:0]    out_channel,
    input  tdl_pkg::cfg_t                 cfg,
    output tdl_pkg::ram_req_t             ram_req,
    input  tdl_pkg::entry_t               rd_data
);
    import tdl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_AGE    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                     chk_vld_reg, chk_vld_next;
    idx_t                     chk_addr_reg, chk_addr_next;
    logic                     hit_reg, hit_next;
    idx_t                     hit_idx_reg, hit_idx_next;
    logic [PRESENT_W-1:0]     hit_present_reg, hit_present_next;
    logic                     free_reg, free_next;
    idx_t                     free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0] seen_reg, seen_next;
    logic                     alarm_reg, alarm_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_alarm_reg, out_alarm_next;
    logic                     out_ovf_reg, out_ovf_next;
    logic [CHAN_W-1:0]        out_chan_reg, out_chan_next;
    logic [ID_W-1:0]          id_reg;
    logic [CHAN_W-1:0]        chan_reg;

    logic                     accept;
    logic                     last_chk;
    logic [PRESENT_W-1:0]     present_new;
    logic [MISSING_W-1:0]     missing_new;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid & in_ready;
    assign last_chk    = chk_vld_reg && (chk_addr_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign present_new = hit_reg ? present_inc(hit_present_reg) : PRESENT_W'(1);
    assign missing_new = missing_inc(rd_data.missing);

    // Next-state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        rd_cnt_next      = rd_cnt_reg;
        chk_vld_next     = 1'b0;
        chk_addr_next    = chk_addr_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_present_next = hit_present_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        valid_next       = valid_reg;
        seen_next        = seen_reg;
        alarm_next       = alarm_reg;
        ovf_next         = ovf_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        out_alarm_next   = out_alarm_reg;
        out_ovf_next     = out_ovf_reg;
        out_chan_next    = out_chan_reg;
        ram_req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_cnt_next = '0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    state_next  = (operation == OP_EOF) ? S_AGE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue reads in address order
                if (rd_cnt_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next     = rd_cnt_reg + CNT_W'(1);
                    chk_vld_next    = 1'b1;
                    chk_addr_next   = rd_cnt_reg[IDX_W-1:0];
                end
                // Record first matching id and first free slot
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_addr_reg] && (rd_data.id == id_reg) && !hit_reg)
                    begin
                        hit_next         = 1'b1;
                        hit_idx_next     = chk_addr_reg;
                        hit_present_next = rd_data.present;
                    end
                    if (!valid_reg[chk_addr_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_addr_reg;
                    end
                end
                if (last_chk)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (hit_reg)
                begin
                    ram_req.wr_en           = 1'b1;
                    ram_req.wr_addr         = hit_idx_reg;
                    ram_req.wr_data.id      = id_reg;
                    ram_req.wr_data.present = present_new;
                    ram_req.wr_data.missing = '0;
                    seen_next[hit_idx_reg]  = 1'b1;
                    if (present_new >= cfg.threshold)
                    begin
                        alarm_next = 1'b1;
                    end
                end
                else if (free_reg)
                begin
                    ram_req.wr_en           = 1'b1;
                    ram_req.wr_addr         = free_idx_reg;
                    ram_req.wr_data.id      = id_reg;
                    ram_req.wr_data.present = present_new;
                    ram_req.wr_data.missing = '0;
                    valid_next[free_idx_reg] = 1'b1;
                    seen_next[free_idx_reg]  = 1'b1;
                    if (present_new >= cfg.threshold)
                    begin
                        alarm_next = 1'b1;
                    end
                end
                else
                begin
                    // Table full: drop the id
                    ovf_next = 1'b1;
                end
                state_next = S_IDLE;
            end

            S_AGE:
            begin
                if (rd_cnt_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next     = rd_cnt_reg + CNT_W'(1);
                    chk_vld_next    = 1'b1;
                    chk_addr_next   = rd_cnt_reg[IDX_W-1:0];
                end
                // Age unseen entries one behind the read; evict stale ones
                if (chk_vld_reg && valid_reg[chk_addr_reg])
                begin
                    if (seen_reg[chk_addr_reg])
                    begin
                        seen_next[chk_addr_reg] = 1'b0;
                    end
                    else
                    begin
                        ram_req.wr_en           = 1'b1;
                        ram_req.wr_addr         = chk_addr_reg;
                        ram_req.wr_data.id      = rd_data.id;
                        ram_req.wr_data.present = rd_data.present;
                        ram_req.wr_data.missing = missing_new;
                        if (missing_new > cfg.max_lost)
                        begin
                            valid_next[chk_addr_reg] = 1'b0;
                        end
                    end
                end
                if (last_chk)
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                // Hand the frame result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_alarm_next = alarm_reg;
                    out_ovf_next   = ovf_reg;
                    out_chan_next  = chan_reg;
                    alarm_next     = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            seen_reg      <= '0;
            alarm_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            valid_reg     <= valid_next;
            seen_reg      <= seen_next;
            alarm_reg     <= alarm_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_addr_reg    <= chk_addr_next;
        hit_idx_reg     <= hit_idx_next;
        hit_present_reg <= hit_present_next;
        free_idx_reg    <= free_idx_next;
        out_alarm_reg   <= out_alarm_next;
        out_ovf_reg     <= out_ovf_next;
        out_chan_reg    <= out_chan_next;
        if (accept)
        begin
            id_reg   <= obj_id;
            chan_reg <= channel_id;
        end
    end

    assign out_valid      = out_valid_reg;
    assign loiter_alarm   = out_alarm_reg;
    assign table_overflow = out_ovf_reg;
    assign out_channel    = out_chan_reg;

endmodule
